@@ sv/omfw_pkg.sv @@
// Package for the owned mutex with FIFO waiters.
// Holds shared constants, status codes and the cell control struct.
// No dependencies.
`default_nettype none
package omfw_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_W            = 8;
	localparam int STATUS_W        = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED = 3'd0,
		ST_QUEUED  = 3'd1,
		ST_FREED   = 3'd2,
		ST_HANDOFF = 3'd3,
		ST_IGNORED = 3'd4,
		ST_FULL    = 3'd5
	} status_t;

	typedef enum logic {
		OP_ACQUIRE = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage
`default_nettype wire

@@ sv/omfw_cell.sv @@
// One waiter cell of the queue chain: loads a new ID or takes its neighbor's ID.
// Depends on omfw_pkg.
`default_nettype none
module omfw_cell
	import omfw_pkg::*;
(
	input  wire logic            clk,
	input  wire cell_ctrl_t      ctrl,
	input  wire logic [ID_W-1:0] load_id,
	input  wire logic [ID_W-1:0] next_id,
	output logic      [ID_W-1:0] id
);

	logic [ID_W-1:0] id_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			id_q <= load_id;
		end else if (ctrl.shift) begin
			id_q <= next_id;
		end
	end

	assign id = id_q;

endmodule
`default_nettype wire

@@ sv/omfw_chain.sv @@
// Wait queue as a row of cells; cell 0 is the oldest waiter, pop shifts toward it.
// Depends on omfw_pkg and omfw_cell.
`default_nettype none
module omfw_chain
	import omfw_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             push,
	input  wire logic             pop,
	input  wire logic [ID_W-1:0]  push_id,
	input  wire logic [CNT_W-1:0] count,
	output logic      [ID_W-1:0]  head_id
);

	logic [ID_W-1:0] cell_id [QUEUE_DEPTH];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cell_ctrl_t      ctrl;
		logic [ID_W-1:0] next_id;

		assign ctrl.load  = push && (count == CNT_W'(i));
		assign ctrl.shift = pop;

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_id = '0;
		end else begin : g_mid
			assign next_id = cell_id[i+1];
		end

		omfw_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.load_id (push_id),
			.next_id (next_id),
			.id      (cell_id[i])
		);
	end

	assign head_id = cell_id[0];

endmodule
`default_nettype wire

@@ sv/owned_mutex_fifo_waiters_top.sv @@
// Top level of the owned mutex with a FIFO of blocked requesters.
// Depends on omfw_pkg and omfw_chain.
//
// channel   handshake            payload
// request   start / busy         op, requester_id
// result    done (one cycle)     status, owner_id, held, waiters
//
// One request per cycle; busy is never raised. The result of a request taken
// at one edge is on the result ports, with done, during the following cycle.
// The queue is a row of cells, so a push or pop completes in that same cycle.
// Reset clears lock, owner and count; queue entries are unset until written.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none
module owned_mutex_fifo_waiters_top
	import omfw_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                op,
	input  wire logic [ID_W-1:0]     requester_id,
	output logic                     done,
	output logic      [STATUS_W-1:0] status,
	output logic      [ID_W-1:0]     owner_id,
	output logic                     held,
	output logic      [CNT_W-1:0]    waiters
);

	logic             held_q;
	logic [ID_W-1:0]  owner_q;
	logic [CNT_W-1:0] count_q;
	logic             done_q;
	status_t          status_q;

	logic             accept;
	logic             push;
	logic             pop;
	logic [ID_W-1:0]  head_id;
	status_t          status_d;
	logic             held_d;
	logic [ID_W-1:0]  owner_d;
	logic [CNT_W-1:0] count_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		push     = 1'b0;
		pop      = 1'b0;
		held_d   = held_q;
		owner_d  = owner_q;
		count_d  = count_q;
		status_d = ST_IGNORED;
		if (op_t'(op) == OP_ACQUIRE) begin
			if (!held_q) begin
				held_d   = 1'b1;
				owner_d  = requester_id;
				status_d = ST_GRANTED;
			end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
				status_d = ST_FULL;
			end else begin
				push     = accept;
				count_d  = count_q + CNT_W'(1);
				status_d = ST_QUEUED;
			end
		end else begin
			if (!held_q || owner_q != requester_id) begin
				status_d = ST_IGNORED;
			end else if (count_q != '0) begin
				pop      = accept;
				owner_d  = head_id;
				count_d  = count_q - CNT_W'(1);
				status_d = ST_HANDOFF;
			end else begin
				held_d   = 1'b0;
				owner_d  = '0;
				status_d = ST_FREED;
			end
		end
	end

	omfw_chain #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_chain (
		.clk     (clk),
		.push    (push),
		.pop     (pop),
		.push_id (requester_id),
		.count   (count_q),
		.head_id (head_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 1'b0;
			owner_q  <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_GRANTED;
		end else begin
			done_q <= accept;
			if (accept) begin
				held_q   <= held_d;
				owner_q  <= owner_d;
				count_q  <= count_d;
				status_q <= status_d;
			end
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign owner_id = owner_q;
	assign held     = held_q;
	assign waiters  = count_q;

endmodule
`default_nettype wire
